### rtl/psa_pkg.sv
// psa_pkg: shared types and constants for the pixel saturation adjust core.
// No dependencies; imported by the core, psa_prep, psa_div_stage and the testbench.
package psa_pkg;

    localparam int K_W        = 12;   // width of the Q4.8 saturation factor
    localparam int ALPHA_W    = 16;   // alpha is always carried at full width
    localparam int PORT_CHAN_W = 16;  // channel width on the stream ports
    localparam int UNITY_Q8   = 256;  // 1.0 in Q4.8
    localparam int LUMA_B     = 28;
    localparam int LUMA_G     = 151;
    localparam int LUMA_R     = 77;
    localparam int NUM_CHAN   = 3;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_BLEND = 2'd1,
        MODE_HSV   = 2'd2
    } mode_t;

    // Control that travels with each item through the divider pipeline.
    typedef struct packed {
        logic       valid;
        logic [2:0] is_mid;   // channel that still needs the quotient added
    } ctrl_t;

endpackage

### rtl/pixel_saturation_adjust_core.sv
// pixel_saturation_adjust_core: top level of the saturation adjust block.
// Depends on psa_pkg, psa_prep and psa_div_stage.
//
// Changes the saturation of one BGRA pixel per clock by the Q4.8 factor in
// saturation_q8 (reset 256 = unchanged). Below 1.0 each colour channel blends
// toward luma (28B+151G+77R)>>8; above 1.0 an integer hexcone HSV scaling keeps
// the max channel and the hue, scales the max-min spread (capped at full
// saturation) and rebuilds the min and mid channels; alpha is copied. The
// pipeline takes one item per cycle unless stalled; it holds four preparation
// stages, one stage per quotient bit of the mid-channel divider, and the output
// register. The whole pipeline advances together whenever the output register
// is empty or being taken, so s_tready falls only while a finished item waits
// at the output. Write saturation_q8 only while idle.
module pixel_saturation_adjust_core #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,     // saturation_q8
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // blue_in, green_in, red_in, alpha_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata        // blue_out, green_out, red_out, alpha_out
);
    import psa_pkg::*;

    localparam int W = CHANNEL_BITS;
    localparam int NSTG = W;          // one divider stage per quotient bit
    localparam logic [W-1:0] CMAX = {W{1'b1}};

    logic [K_W-1:0] saturation_q8_reg;
    logic           en;

    // Advance the pipeline when the output slot is free or being drained.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            saturation_q8_reg <= K_W'(UNITY_Q8);
        else if (cfg_we)
            saturation_q8_reg <= cfg_wdata;
    end

    // Divider chain: index 0 is the preparation output.
    ctrl_t              dv_ctrl  [NSTG+1];
    logic [3*W-1:0]     dv_base  [NSTG+1];
    logic [ALPHA_W-1:0] dv_alpha [NSTG+1];
    logic [W-1:0]       dv_d     [NSTG+1];
    logic [W-1:0]       dv_rem   [NSTG+1];
    logic [W-1:0]       dv_pq    [NSTG+1];

    psa_prep #(.W(W)) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_b      (s_tdata[W-1:0]),
        .in_g      (s_tdata[PORT_CHAN_W +: W]),
        .in_r      (s_tdata[2*PORT_CHAN_W +: W]),
        .in_alpha  (s_tdata[3*PORT_CHAN_W +: ALPHA_W]),
        .in_k      (saturation_q8_reg),
        .out_ctrl  (dv_ctrl[0]),
        .out_base  (dv_base[0]),
        .out_alpha (dv_alpha[0]),
        .out_d     (dv_d[0]),
        .out_rem   (dv_rem[0]),
        .out_pq    (dv_pq[0])
    );

    for (genvar s = 0; s < NSTG; s++)
    begin : g_div
        psa_div_stage #(.W(W)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_ctrl   (dv_ctrl[s]),
            .in_base   (dv_base[s]),
            .in_alpha  (dv_alpha[s]),
            .in_d      (dv_d[s]),
            .in_rem    (dv_rem[s]),
            .in_pq     (dv_pq[s]),
            .out_ctrl  (dv_ctrl[s+1]),
            .out_base  (dv_base[s+1]),
            .out_alpha (dv_alpha[s+1]),
            .out_d     (dv_d[s+1]),
            .out_rem   (dv_rem[s+1]),
            .out_pq    (dv_pq[s+1])
        );
    end

    // Add the quotient onto the mid channel, clamp, widen to port width.
    logic [W:0]   fsum;
    logic [63:0]  out_data;

    always_comb
    begin
        out_data = '0;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            fsum = (W+1)'(dv_base[NSTG][i*W +: W]);
            if (dv_ctrl[NSTG].is_mid[i])
                fsum = fsum + (W+1)'(dv_pq[NSTG]);
            out_data[i*PORT_CHAN_W +: PORT_CHAN_W] =
                PORT_CHAN_W'((fsum > (W+1)'(CMAX)) ? CMAX : fsum[W-1:0]);
        end
        out_data[3*PORT_CHAN_W +: ALPHA_W] = dv_alpha[NSTG];
    end

    // Output register: hold the item until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (en)
            m_tvalid <= dv_ctrl[NSTG].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            m_tdata <= out_data;
    end

endmodule

### rtl/psa_prep.sv
// psa_prep: four pipeline stages that find max/min/luma, scale the spread,
// blend toward luma and form the dividend for the hue-preserving mid channel.
// Depends on psa_pkg.
module psa_prep #(
    parameter int W = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [W-1:0]             in_b,
    input  logic [W-1:0]             in_g,
    input  logic [W-1:0]             in_r,
    input  logic [psa_pkg::ALPHA_W-1:0] in_alpha,
    input  logic [psa_pkg::K_W-1:0]  in_k,
    output psa_pkg::ctrl_t           out_ctrl,
    output logic [3*W-1:0]           out_base,
    output logic [psa_pkg::ALPHA_W-1:0] out_alpha,
    output logic [W-1:0]             out_d,
    output logic [W-1:0]             out_rem,
    output logic [W-1:0]             out_pq
);
    import psa_pkg::*;

    localparam logic [W-1:0] CMAX = {W{1'b1}};

    // ---------------- stage A: max, min, mid, luma sum ----------------
    logic [W-1:0]   c [NUM_CHAN];
    logic [W-1:0]   mx, mn, mid;
    logic [W+1:0]   sum3;
    logic [W+7:0]   luma_sum;
    logic [2:0]     is_max, is_min;
    mode_t          mode;

    always_comb
    begin
        c[0] = in_b;
        c[1] = in_g;
        c[2] = in_r;
        mx = in_b;
        mn = in_b;
        if (in_g > mx) mx = in_g;
        if (in_r > mx) mx = in_r;
        if (in_g < mn) mn = in_g;
        if (in_r < mn) mn = in_r;
        sum3 = (W+2)'(in_b) + (W+2)'(in_g) + (W+2)'(in_r) - (W+2)'(mx) - (W+2)'(mn);
        mid  = sum3[W-1:0];
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            is_max[i] = (c[i] == mx);
            is_min[i] = (c[i] == mn);
        end
        luma_sum = (W+8)'(LUMA_B) * (W+8)'(in_b) + (W+8)'(LUMA_G) * (W+8)'(in_g)
                 + (W+8)'(LUMA_R) * (W+8)'(in_r);
        if (in_k < K_W'(UNITY_Q8))
            mode = MODE_BLEND;
        else if (in_k > K_W'(UNITY_Q8) && mx != mn)
            mode = MODE_HSV;
        else
            mode = MODE_PASS;
    end

    logic           a_valid_reg;
    mode_t          a_mode_reg;
    logic [2:0]     a_max_reg, a_min_reg;
    logic [W-1:0]   a_c_reg [NUM_CHAN];
    logic [ALPHA_W-1:0] a_alpha_reg;
    logic [K_W-1:0] a_k_reg;
    logic [W-1:0]   a_mx_reg, a_mn_reg, a_mid_reg, a_d_reg;
    logic [W+7:0]   a_luma_reg;

    // ---------------- stage B: luma, spread times factor ----------------
    logic           b_valid_reg;
    mode_t          b_mode_reg;
    logic [2:0]     b_max_reg, b_min_reg;
    logic [W-1:0]   b_c_reg [NUM_CHAN];
    logic [ALPHA_W-1:0] b_alpha_reg;
    logic [K_W-1:0] b_k_reg;
    logic [W-1:0]   b_mx_reg, b_d_reg, b_span_reg, b_luma_reg;
    logic [W+K_W-1:0] b_dk_reg;

    // ---------------- stage C: capped spread, blend sums ----------------
    logic [W+3:0]   dk_sh;
    logic [W-1:0]   d_new;
    logic [8:0]     inv_k;
    logic [W+8:0]   bsum [NUM_CHAN];

    always_comb
    begin
        dk_sh = b_dk_reg[W+K_W-1:8];
        d_new = (dk_sh > (W+4)'(b_mx_reg)) ? b_mx_reg : dk_sh[W-1:0];
        inv_k = 9'(UNITY_Q8) - b_k_reg[8:0];
        for (int i = 0; i < NUM_CHAN; i++)
            bsum[i] = (W+9)'(b_c_reg[i]) * (W+9)'(b_k_reg[7:0])
                    + (W+9)'(b_luma_reg) * (W+9)'(inv_k);
    end

    logic           c_valid_reg;
    mode_t          c_mode_reg;
    logic [2:0]     c_max_reg, c_min_reg;
    logic [W-1:0]   c_c_reg [NUM_CHAN];
    logic [ALPHA_W-1:0] c_alpha_reg;
    logic [W-1:0]   c_mx_reg, c_d_reg, c_span_reg, c_dnew_reg;
    logic [W+8:0]   c_bsum_reg [NUM_CHAN];

    // ---------------- stage D: new min, dividend, channel bases ----------------
    logic [W-1:0]   low;
    logic [2*W-1:0] prod;
    logic [W:0]     bres;
    logic [3*W-1:0] base;
    logic [2:0]     mid_flag;

    always_comb
    begin
        low  = c_mx_reg - c_dnew_reg;
        prod = (2*W)'(c_dnew_reg) * (2*W)'(c_span_reg);
        base = '0;
        mid_flag = '0;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            bres = c_bsum_reg[i][W+8:8];
            case (c_mode_reg)
                MODE_BLEND: base[i*W +: W] = (bres > (W+1)'(CMAX)) ? CMAX : bres[W-1:0];
                MODE_HSV:
                begin
                    base[i*W +: W] = c_max_reg[i] ? c_mx_reg : low;
                    mid_flag[i]    = !c_max_reg[i] && !c_min_reg[i];
                end
                default:    base[i*W +: W] = c_c_reg[i];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            out_ctrl    <= '0;
        end
        else if (en)
        begin
            a_valid_reg     <= in_valid;
            b_valid_reg     <= a_valid_reg;
            c_valid_reg     <= b_valid_reg;
            out_ctrl.valid  <= c_valid_reg;
            out_ctrl.is_mid <= mid_flag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mode_reg  <= mode;
            a_max_reg   <= is_max;
            a_min_reg   <= is_min;
            a_c_reg     <= c;
            a_alpha_reg <= in_alpha;
            a_k_reg     <= in_k;
            a_mx_reg    <= mx;
            a_mn_reg    <= mn;
            a_mid_reg   <= mid;
            a_d_reg     <= mx - mn;
            a_luma_reg  <= luma_sum;

            b_mode_reg  <= a_mode_reg;
            b_max_reg   <= a_max_reg;
            b_min_reg   <= a_min_reg;
            b_c_reg     <= a_c_reg;
            b_alpha_reg <= a_alpha_reg;
            b_k_reg     <= a_k_reg;
            b_mx_reg    <= a_mx_reg;
            b_d_reg     <= a_d_reg;
            b_span_reg  <= a_mid_reg - a_mn_reg;
            b_luma_reg  <= a_luma_reg[W+7:8];
            b_dk_reg    <= (W+K_W)'(a_d_reg) * (W+K_W)'(a_k_reg);

            c_mode_reg  <= b_mode_reg;
            c_max_reg   <= b_max_reg;
            c_min_reg   <= b_min_reg;
            c_c_reg     <= b_c_reg;
            c_alpha_reg <= b_alpha_reg;
            c_mx_reg    <= b_mx_reg;
            c_d_reg     <= b_d_reg;
            c_span_reg  <= b_span_reg;
            c_dnew_reg  <= d_new;
            c_bsum_reg  <= bsum;

            out_base        <= base;
            out_alpha       <= c_alpha_reg;
            out_d           <= c_d_reg;
            out_rem         <= prod[2*W-1:W];
            out_pq          <= prod[W-1:0];
        end
    end

endmodule

### rtl/psa_div_stage.sv
// psa_div_stage: one restoring-division step (one quotient bit) of the
// pipelined divider that rebuilds the mid channel. Depends on psa_pkg.
module psa_div_stage #(
    parameter int W = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  psa_pkg::ctrl_t           in_ctrl,
    input  logic [3*W-1:0]           in_base,
    input  logic [psa_pkg::ALPHA_W-1:0] in_alpha,
    input  logic [W-1:0]             in_d,
    input  logic [W-1:0]             in_rem,
    input  logic [W-1:0]             in_pq,
    output psa_pkg::ctrl_t           out_ctrl,
    output logic [3*W-1:0]           out_base,
    output logic [psa_pkg::ALPHA_W-1:0] out_alpha,
    output logic [W-1:0]             out_d,
    output logic [W-1:0]             out_rem,
    output logic [W-1:0]             out_pq
);
    import psa_pkg::*;

    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         qbit;
    logic [W-1:0] rem_next;

    always_comb
    begin
        trial    = {in_rem, in_pq[W-1]};
        diff     = trial - (W+1)'(in_d);
        qbit     = (trial >= (W+1)'(in_d));
        rem_next = qbit ? diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ctrl <= '0;
        else if (en)
            out_ctrl <= in_ctrl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_base        <= in_base;
            out_alpha       <= in_alpha;
            out_d           <= in_d;
            out_rem         <= rem_next;
            out_pq          <= {in_pq[W-2:0], qbit};
        end
    end

endmodule

### rtl/psa_checker.sv
// psa_checker: port-level assertions for pixel_saturation_adjust_core,
// attached by the bind statement below. Depends on nothing else.
module psa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // A stalled output item stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    // Input side stalls only when a finished item is waiting at the output.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with output free");

    // An empty output slot always lets the pipeline advance.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready with empty output");

    // Stalled output data holds.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed while stalled");

endmodule

bind pixel_saturation_adjust_core psa_checker u_psa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/tb_pixel_saturation_adjust_core.sv
// Self-checking testbench for pixel_saturation_adjust_core: random BGRA pixels
// under several saturation factors, checked against an in-bench predictor.
// Depends on psa_pkg and the RTL of the core.
module tb_pixel_saturation_adjust_core;
    import psa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAN_W = 16;
    localparam int LATENCY = CHAN_W + 5;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [K_W-1:0] K_ZERO = '0;
    localparam logic [K_W-1:0] K_MAX = '1;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pixel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [11:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [63:0] s_tdata;      // blue_in, green_in, red_in, alpha_in
    logic m_tvalid;
    logic m_tready;
    logic [63:0] m_tdata;      // blue_out, green_out, red_out, alpha_out

    pixel_t pending_pixels[$];
    pixel_t expected_pixels[$];
    logic [K_W-1:0] sat_factor;   // predictor's copy of saturation_q8

    int mismatch_count;
    int pixels_sent;
    int pixels_checked;
    int idle_cycles;
    int rx_hold_left;
    bit tx_idle_en;
    bit rx_idle_en;
    bit rx_hold;
    bit in_accepted;
    bit timed_out;

    pixel_saturation_adjust_core #(.CHANNEL_BITS(CHAN_W)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Rebuild one channel of the hexcone HSV scaling.
    function automatic logic [15:0] rebuild_chan(input logic [15:0] c,
        input logic [15:0] mx, input logic [15:0] mn, input logic [31:0] d,
        input logic [31:0] d_new);
        logic [63:0] v;
        v = 64'(mx) - d_new;
        if (c >= mx)
            return mx;
        if (c <= mn)
            return v[15:0];
        v = v + (64'(d_new) * (c - mn)) / d;
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] blend_chan(input logic [15:0] c,
        input logic [31:0] luma, input logic [K_W-1:0] k);
        logic [63:0] v;
        v = (64'(c) * k + 64'(luma) * (UNITY_Q8 - k)) >> 8;
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    // Compute the adjusted pixel for the current saturation factor.
    function automatic pixel_t adjust_saturation(input pixel_t p);
        pixel_t q;
        logic [31:0] luma;
        logic [15:0] mx;
        logic [15:0] mn;
        logic [31:0] d;
        logic [31:0] d_new;
        q = p;
        if (sat_factor < UNITY_Q8)
        begin
            luma = (LUMA_B * p.blue + LUMA_G * p.green + LUMA_R * p.red) >> 8;
            q.blue = blend_chan(p.blue, luma, sat_factor);
            q.green = blend_chan(p.green, luma, sat_factor);
            q.red = blend_chan(p.red, luma, sat_factor);
        end
        else if (sat_factor > UNITY_Q8)
        begin
            mx = p.blue;
            mn = p.blue;
            if (p.green > mx) mx = p.green;
            if (p.red > mx) mx = p.red;
            if (p.green < mn) mn = p.green;
            if (p.red < mn) mn = p.red;
            d = mx - mn;
            // Grey pixel: no hue, leave the channels alone.
            if (d != 0)
            begin
                d_new = (d * sat_factor) >> 8;
                if (d_new > mx)
                    d_new = mx;
                q.blue = rebuild_chan(p.blue, mx, mn, d, d_new);
                q.green = rebuild_chan(p.green, mx, mn, d, d_new);
                q.red = rebuild_chan(p.red, mx, mn, d, d_new);
            end
        end
        return q;
    endfunction

    // Driver: offer the next pending item, advance on acceptance.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_accepted)
                void'(pending_pixels.pop_front());
            if (pending_pixels.size() != 0 &&
                !(tx_idle_en && $urandom_range(99) < 14))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_pixels[0];
            end
            else
            begin
                s_tvalid <= 1'b0;
                s_tdata <= 64'(pixel_t'($urandom));
            end
            m_tready <= !rx_hold && !(rx_idle_en && $urandom_range(99) < 14);
        end
    end

    // Receiver hold-off: count down the requested stretch of stalled cycles.
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            rx_hold = 1'b1;
            rx_hold_left--;
        end
        else
            rx_hold = 1'b0;
    end

    // Monitor: predict on input acceptance, check on output acceptance.
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        in_accepted = rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_pixels.push_back(adjust_saturation(pixel_t'(s_tdata)));
                pixels_sent++;
            end
            if (m_tvalid && m_tready)
            begin
                got = pixel_t'(m_tdata);
                pixels_checked++;
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected item %h", got);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("ERROR: k=%0d exp b=%h g=%h r=%h a=%h got b=%h g=%h r=%h a=%h",
                                     sat_factor, want.blue, want.green, want.red, want.alpha,
                                     got.blue, got.green, got.red, got.alpha);
                    end
                end
            end
            // Watchdog: count cycles with no handshake on either side.
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("pixel_saturation_adjust_core regression: fail");
            $finish;
        end
    end

    function automatic pixel_t random_pixel();
        pixel_t p;
        p = pixel_t'({$urandom, $urandom});
        case ($urandom_range(5))
            0: p.green = p.blue;                            // tie
            1: begin p.green = p.blue; p.red = p.blue; end  // grey
            2: begin p.blue = $urandom_range(255); p.red = 16'hFFFF; end
            default: ;
        endcase
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Write the factor while idle; keep the predictor in step.
    task automatic set_factor(input logic [K_W-1:0] k);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= k;
        @(negedge clk);
        cfg_we <= 1'b0;
        sat_factor = k;
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_pixels.push_back(random_pixel());
    endtask

    initial
    begin
        logic [K_W-1:0] factors[7];
        pixel_t p;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        sat_factor = K_W'(UNITY_Q8);
        mismatch_count = 0;
        pixels_sent = 0;
        pixels_checked = 0;
        idle_cycles = 0;
        rx_hold_left = 0;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold = 1'b0;
        in_accepted = 1'b0;
        timed_out = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes at reset factor, then at zero and at maximum.
        for (int f = 0; f < 3; f++)
        begin
            if (f == 1) set_factor(K_ZERO);
            if (f == 2) set_factor(K_MAX);
            pending_pixels.push_back(64'h0);
            pending_pixels.push_back(64'hFFFF_FFFF_FFFF_FFFF);
            pending_pixels.push_back({16'h1234, 16'hFFFF, 16'h0000, 16'h0000});
            pending_pixels.push_back({16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF});
            pending_pixels.push_back({16'hAAAA, 16'h4000, 16'h4000, 16'h4000});
            pending_pixels.push_back({16'h5555, 16'h0100, 16'h0001, 16'h0100});
            pending_pixels.push_back({16'h0001, 16'hFFFF, 16'h0001, 16'hFFFE});
        end

        factors = '{K_W'(UNITY_Q8), K_ZERO, 12'd128, 12'd255, 12'd257, 12'd512, K_MAX};
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        foreach (factors[i])
        begin
            set_factor(factors[i]);
            // Sender pause: wait out all results before the next batch.
            queue_random(25);
            wait_drained();
            queue_random(25);
            if (i == 3)
            begin
                // Receiver holds off long enough for the input to stall.
                while (pending_pixels.size() > 15) @(negedge clk);
                rx_hold_left = 3 * LATENCY;
            end
        end

        // A stretch with no idling on either side.
        set_factor(12'd384);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        queue_random(40);
        wait_drained();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        set_factor(12'($urandom_range(4095)));
        queue_random(30);
        wait_drained();

        $display("covered %0d pixels, %0d results checked, factors 0..4095 incl. unity",
                 pixels_sent, pixels_checked);
        if (mismatch_count == 0)
            $display("pixel_saturation_adjust_core regression: pass");
        else
            $display("pixel_saturation_adjust_core regression: fail");
        $finish;
    end

endmodule
